[hdl/stfir_pkg.sv]
// Package for the sparse-tap FIR filter: widths, register indexes, sequencer states.
// No dependencies; imported by sparse_tap_fir_filter.
package stfir_pkg;

  // Default build values
  localparam int HISTORY_DEPTH  = 64;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 16;

  // Fixed field layout
  localparam int MAX_TAPS   = 6;
  localparam int COEF_W     = 18;
  localparam int DELAY_W    = 6;
  localparam int TAP_WORD_W = 24;
  localparam int SCALE_W    = 18;
  localparam int COUNT_W    = 3;
  localparam int TAP_IDX_W  = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 18'sd65536;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TAP_COUNT = 3'd0;
  localparam logic [2:0] REG_SCALE     = 3'd1;
  localparam logic [2:0] REG_TAP_WORD0 = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_ROUND,
    ST_SCALE,
    ST_FINISH
  } state_e;

endpackage

[hdl/sparse_tap_fir_filter.sv]
// Sparse-tap FIR filter top level: APB register file, history memory, one shared
// multiplier under a small sequencer. Depends on stfir_pkg.
//
// Usage
//   Input words arrive on s_axis_*: tdata carries the signed sample, tuser the
//   first flag, which empties the history before that sample is stored.
//   One result word leaves on m_axis_* per input word: tdata the saturated
//   32-bit value, tuser the clip flag.
//   Taps, tap count and the common scale are set over the APB port while the
//   filter is idle; pready is tied high, reads return the stored registers.
// Sequence
//   Each word takes one accept step, one issue step per tap (n, the tap count
//   in use, 0..6), a drain of the read, multiply and add of the last tap, then
//   round, scale and finish. Taps are issued one at a time, as there is one
//   history read port and one shared multiplier. s_axis_tready is high only
//   while idle, so a new word waits until the last result is registered.
// Reset and stalls
//   Reset empties the history (fill count to zero, no clearing pass), sets
//   scale to 1.0 and clears all taps. The result sits in an output register;
//   the next word may be taken while it waits, and the sequencer holds in its
//   finish step until the register is free.
module sparse_tap_fir_filter #(
  parameter int HISTORY_DEPTH  = stfir_pkg::HISTORY_DEPTH,
  parameter int SAMPLE_WIDTH   = stfir_pkg::SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = stfir_pkg::COEF_FRAC_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // input stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // sample
  input  logic                                    s_axis_tuser,  // first
  // output stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [31:0]                             m_axis_tdata,  // value
  output logic                                    m_axis_tuser,  // saturated
  // configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [stfir_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [stfir_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [stfir_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                    pready
);
  import stfir_pkg::*;

  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W   = (FILL_W > DELAY_W) ? FILL_W : DELAY_W;
  localparam int DIF_W   = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
  localparam int ACC_W   = SAMPLE_WIDTH + COEF_W + 3;          // six products
  localparam int S_W     = ACC_W + 1 - COEF_FRAC_BITS;         // rounded tap sum
  localparam int MUL_A_W = (S_W > SAMPLE_WIDTH) ? S_W : SAMPLE_WIDTH;
  localparam int PROD_W  = MUL_A_W + COEF_W;
  localparam int TAPP_W  = SAMPLE_WIDTH + COEF_W;
  localparam int P_W     = S_W + SCALE_W;
  localparam int EXT_W   = (P_W + 1 > 34) ? P_W + 1 : 34;

  localparam logic [ACC_W:0]   ACC_HALF = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [EXT_W-1:0] EXT_HALF = EXT_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] R_MAX = {{(EXT_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [EXT_W-1:0] R_MIN = {{(EXT_W-31){1'b1}}, {31{1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]        tap_count_q;
  logic signed [SCALE_W-1:0] scale_q;
  logic [TAP_WORD_W-1:0]     tap_word_q [MAX_TAPS];
  logic [2:0]                reg_idx;
  logic                      cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= '0;
      scale_q     <= SCALE_RESET;
      for (int i = 0; i < MAX_TAPS; i++) tap_word_q[i] <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TAP_COUNT: tap_count_q <= pwdata[COUNT_W-1:0];
        REG_SCALE:     scale_q     <= pwdata[SCALE_W-1:0];
        default:       tap_word_q[reg_idx - REG_TAP_WORD0] <= pwdata[TAP_WORD_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TAP_COUNT: prdata = APB_DATA_W'(tap_count_q);
      REG_SCALE:     prdata = APB_DATA_W'(unsigned'(scale_q));
      default:       prdata = APB_DATA_W'(tap_word_q[reg_idx - REG_TAP_WORD0]);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [COUNT_W-1:0]        n_taps;
  logic [TAP_IDX_W-1:0]      k_q;
  logic                      in_acc, issue, out_free, out_load, prod_en;
  logic                      p1_q, p2_q;

  // a tap count above six means six
  assign n_taps   = (tap_count_q > COUNT_W'(MAX_TAPS)) ? COUNT_W'(MAX_TAPS) : tap_count_q;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_TAP;
      ST_TAP:    if (!(k_q < n_taps) && !p1_q && !p2_q) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    in_acc        = s_axis_tvalid && (state_q == ST_IDLE);
    issue         = (state_q == ST_TAP) && (k_q < n_taps);
    prod_en       = p1_q || (state_q == ST_SCALE);
    out_load      = (state_q == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // History memory and fill tracking
  // ---------------------------------------------------------------------------
  logic [SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rdata_q;
  logic [AW-1:0]           wp_q, cur_q, wr_pos, rd_addr;
  logic [FILL_W-1:0]       fill_q;

  assign wr_pos = s_axis_tuser ? '0 : wp_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) hist_mem[wr_pos] <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    rdata_q <= hist_mem[rd_addr];
  end

  // entries older than the fill count read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      cur_q  <= '0;
      fill_q <= '0;
    end else if (in_acc) begin
      cur_q <= wr_pos;
      wp_q  <= (wr_pos == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_pos + AW'(1);
      if (s_axis_tuser)                               fill_q <= FILL_W'(1);
      else if (fill_q != FILL_W'(HISTORY_DEPTH))      fill_q <= fill_q + FILL_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Tap issue: address, use flag, coefficient
  // ---------------------------------------------------------------------------
  logic [TAP_WORD_W-1:0]   tap_sel;
  logic [DELAY_W-1:0]      tap_delay;
  logic                    tap_use;
  logic [DIF_W-1:0]        pos_diff;
  logic signed [COEF_W-1:0] coef1_q;

  assign tap_sel   = (k_q < TAP_IDX_W'(MAX_TAPS)) ? tap_word_q[k_q] : '0;
  assign tap_delay = tap_sel[TAP_WORD_W-1 -: DELAY_W];
  assign tap_use   = CMP_W'(tap_delay) < CMP_W'(fill_q);
  assign pos_diff  = DIF_W'(cur_q) - DIF_W'(tap_delay);
  assign rd_addr   = (DIF_W'(cur_q) < DIF_W'(tap_delay))
                   ? AW'(pos_diff + DIF_W'(HISTORY_DEPTH)) : pos_diff[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      p1_q <= 1'b0;
      p2_q <= 1'b0;
    end else begin
      if (in_acc)     k_q <= '0;
      else if (issue) k_q <= k_q + TAP_IDX_W'(1);
      p1_q <= issue && tap_use;
      p2_q <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) coef1_q <= tap_sel[COEF_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier, accumulator, rounding and clamp
  // ---------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [COEF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [S_W-1:0]     sum_q;
  logic [ACC_W:0]            acc_rnd;
  logic signed [ACC_W:0]     acc_shr;
  logic [EXT_W-1:0]          p_rnd;
  logic signed [EXT_W-1:0]   r_full;
  logic                      sat_hi, sat_lo;

  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_a = MUL_A_W'(sum_q);
      mul_b = scale_q;
    end else begin
      mul_a = MUL_A_W'($signed(rdata_q));
      mul_b = coef1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc)    acc_q <= '0;
    else if (p2_q) acc_q <= acc_q + ACC_W'($signed(prod_q[TAPP_W-1:0]));
  end

  // round half up, then keep the bits the sum can occupy
  assign acc_rnd = {acc_q[ACC_W-1], acc_q} + ACC_HALF;
  assign acc_shr = $signed(acc_rnd) >>> COEF_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) sum_q <= acc_shr[S_W-1:0];
  end

  assign p_rnd  = EXT_W'($signed(prod_q[P_W-1:0])) + EXT_HALF;
  assign r_full = $signed(p_rnd) >>> COEF_FRAC_BITS;
  assign sat_hi = r_full > R_MAX;
  assign sat_lo = r_full < R_MIN;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic        m_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= sat_hi ? R_MAX[31:0] : (sat_lo ? R_MIN[31:0] : r_full[31:0]);
      m_sat_q  <= sat_hi || sat_lo;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;

`ifndef SYNTHESIS
  a_drained_before_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (!p1_q && !p2_q))
    else $error("tap pipeline not drained at rounding");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_accept_starts_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_TAP) && (k_q == '0) && (fill_q != '0))
    else $error("accepted word did not start tap sequence");

  a_tap_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAP) |-> (k_q <= n_taps))
    else $error("tap index ran past tap count");
`endif

endmodule
